// ===== sv/wpsp_pkg.sv =====
// Package for the WAV PCM stream parser: tags, parse phases, status codes,
// result record and result queue sizing. No dependencies.
package wpsp_pkg;

  localparam logic [31:0] TagRiff = 32'h5249_4646;  // "RIFF"
  localparam logic [31:0] TagWave = 32'h5741_5645;  // "WAVE"
  localparam logic [31:0] TagFmt  = 32'h666D_7420;  // "fmt "
  localparam logic [31:0] TagData = 32'h6461_7461;  // "data"

  localparam logic [5:0]  MinFileBytes = 6'd44;
  localparam logic [32:0] FmtMinLen    = 33'd16;

  localparam logic [15:0] FmtPcm      = 16'd1;
  localparam logic [15:0] MonoCount   = 16'd1;
  localparam logic [15:0] Pcm16Bits   = 16'd16;

  // Result queue: two results may enter per request.
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  typedef enum logic [5:0] {
    PhRiff = 6'b000001,
    PhHead = 6'b000010,
    PhFmt  = 6'b000100,
    PhSkip = 6'b001000,
    PhData = 6'b010000,
    PhDone = 6'b100000
  } phase_e;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StShort    = 3'd1,
    StNotRiff  = 3'd2,
    StBadFmt   = 3'd3,
    StNoAudio  = 3'd4
  } status_e;

  typedef enum logic {
    KindSample = 1'b0,
    KindStatus = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] sample;
    status_e            status;
    logic [31:0]        sample_rate;
    logic               last;
  } result_t;

endpackage

// ===== sv/wav_pcm_stream_parser_top.sv =====
// WAV PCM stream parser top level: byte-wise RIFF/WAVE walker and result queue.
// Depends on wpsp_pkg.
//
// Results: a request's results are written into the result queue when it is
//   accepted (sample first, then the final status on an end mark).
// Throughput: one byte per cycle; the output, when not stalled, drains one
//   result per cycle from a 4-entry queue; input stalls below two free entries.
// Reset: rst_ni (async, active low) empties the queue and returns the parser
//   to the RIFF header phase with all format fields zero; the end mark does
//   the same for the parser as its status is queued. No clear pass.
module wav_pcm_stream_parser_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // byte stream in
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               in_byte_i,
  input  logic                     in_end_of_file_i,
  // results out
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     out_kind_o,
  output logic signed [15:0]       out_sample_o,
  output logic [2:0]               out_status_o,
  output logic [31:0]              out_sample_rate_o,
  output logic                     out_last_o
);
  import wpsp_pkg::*;

  // ---------------------------------------------------------------------
  // Parser state
  // ---------------------------------------------------------------------
  phase_e      phase_q, phase_d;
  logic [31:0] bidx_q, bidx_d;        // offset in current header or body
  logic [31:0] tag_q, tag_d;          // tag shift register
  logic [32:0] len_q, len_d;          // declared chunk length
  logic [5:0]  fcnt_q, fcnt_d;        // bytes seen, saturates at 44
  logic        riff_ok_q, riff_ok_d;
  logic [15:0] fmt_q, fmt_d;
  logic [15:0] chans_q, chans_d;
  logic [15:0] bits_q, bits_d;
  logic [31:0] rate_q, rate_d;
  logic [63:0] stg_q, stg_d;          // fmt bytes 0..7 waiting for commit
  logic [15:0] stg_bits_q, stg_bits_d;
  logic [7:0]  low_q, low_d;          // first byte of a sample pair
  logic        seen_q, seen_d;        // any data byte arrived

  logic        in_acc;
  logic        body_end;              // last byte of a padded body
  logic        data_end;              // last byte of the data chunk
  logic        fmt_good_q;
  logic        emit_sample;
  status_e     st;

  assign in_acc = in_valid_i && !in_stall_o;

  // Padded length is at most 2^32, so 33 bits cover both sides.
  assign body_end = ({1'b0, bidx_q} + 33'd1) >= (len_q + {32'd0, len_q[0]});
  assign data_end = ({1'b0, bidx_q} + 33'd1) >= len_q;

  assign fmt_good_q = (fmt_q == FmtPcm) && (chans_q == MonoCount) &&
                      (bits_q == Pcm16Bits);

  always_comb begin
    phase_d     = phase_q;
    bidx_d      = bidx_q;
    tag_d       = tag_q;
    len_d       = len_q;
    fcnt_d      = fcnt_q;
    riff_ok_d   = riff_ok_q;
    fmt_d       = fmt_q;
    chans_d     = chans_q;
    bits_d      = bits_q;
    rate_d      = rate_q;
    stg_d       = stg_q;
    stg_bits_d  = stg_bits_q;
    low_d       = low_q;
    seen_d      = seen_q;
    emit_sample = 1'b0;
    st          = StOk;

    if (in_acc) begin
      if (fcnt_q < MinFileBytes) begin
        fcnt_d = fcnt_q + 6'd1;
      end

      case (phase_q)
        PhRiff: begin
          tag_d = {tag_q[23:0], in_byte_i};
          if (bidx_q == 32'd3) begin
            riff_ok_d = (tag_d == TagRiff);
          end
          if (bidx_q == 32'd11) begin
            riff_ok_d = riff_ok_q && (tag_d == TagWave);
            phase_d   = riff_ok_d ? PhHead : PhDone;
            bidx_d    = 32'd0;
          end else begin
            bidx_d = bidx_q + 32'd1;
          end
        end
        PhHead: begin
          if (bidx_q < 32'd4) begin
            tag_d = {tag_q[23:0], in_byte_i};
            len_d = 33'd0;
          end else begin
            // length bytes land little-endian, offsets 4..7
            len_d = len_q | ({25'd0, in_byte_i} << {bidx_q[1:0], 3'b000});
          end
          if (bidx_q == 32'd7) begin
            bidx_d = 32'd0;
            if (tag_d == TagData) begin
              phase_d = (len_d == 33'd0) ? PhDone : PhData;
            end else if (len_d == 33'd0) begin
              phase_d = PhHead;
            end else begin
              phase_d = (tag_d == TagFmt) ? PhFmt : PhSkip;
            end
          end else begin
            bidx_d = bidx_q + 32'd1;
          end
        end
        PhFmt: begin
          if (bidx_q < 32'd8) begin
            stg_d = stg_q | ({56'd0, in_byte_i} << {bidx_q[2:0], 3'b000});
          end else if (bidx_q == 32'd14) begin
            stg_bits_d = {8'd0, in_byte_i};
          end else if (bidx_q == 32'd15 && len_q >= FmtMinLen) begin
            stg_bits_d = stg_bits_q | {in_byte_i, 8'd0};
            fmt_d      = stg_q[15:0];
            chans_d    = stg_q[31:16];
            rate_d     = stg_q[63:32];
            bits_d     = stg_bits_d;
          end
          if (body_end) begin
            stg_d      = 64'd0;
            stg_bits_d = 16'd0;
            phase_d    = PhHead;
            bidx_d     = 32'd0;
          end else begin
            bidx_d = bidx_q + 32'd1;
          end
        end
        PhSkip: begin
          if (body_end) begin
            phase_d = PhHead;
            bidx_d  = 32'd0;
          end else begin
            bidx_d = bidx_q + 32'd1;
          end
        end
        PhData: begin
          seen_d = 1'b1;
          if (!bidx_q[0]) begin
            low_d = in_byte_i;
          end else if (fmt_good_q && rate_q != 32'd0) begin
            emit_sample = 1'b1;
          end
          if (data_end) begin
            phase_d = PhDone;
          end else begin
            bidx_d = bidx_q + 32'd1;
          end
        end
        default: begin
          // done: ignore bytes until the end mark
        end
      endcase

      if (in_end_of_file_i) begin
        // status is judged on the state after this byte
        if (fcnt_d < MinFileBytes) begin
          st = StShort;
        end else if (!riff_ok_d) begin
          st = StNotRiff;
        end else if (!((fmt_d == FmtPcm) && (chans_d == MonoCount) &&
                       (bits_d == Pcm16Bits))) begin
          st = StBadFmt;
        end else if (rate_d == 32'd0 || !seen_d) begin
          st = StNoAudio;
        end else begin
          st = StOk;
        end
      end
    end
  end

  // Status entry carries the rate before the parser state is cleared.
  result_t res_smp, res_st;
  assign res_smp = '{kind: KindSample, sample: $signed({in_byte_i, low_q}),
                     status: StOk, sample_rate: 32'd0, last: 1'b0};
  assign res_st  = '{kind: KindStatus, sample: 16'sd0, status: st,
                     sample_rate: rate_d, last: 1'b1};

  logic eof_acc;
  assign eof_acc = in_acc && in_end_of_file_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PhRiff;
      bidx_q     <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      fcnt_q     <= '0;
      riff_ok_q  <= 1'b0;
      fmt_q      <= '0;
      chans_q    <= '0;
      bits_q     <= '0;
      rate_q     <= '0;
      stg_q      <= '0;
      stg_bits_q <= '0;
      low_q      <= '0;
      seen_q     <= 1'b0;
    end else if (eof_acc) begin
      // end mark: back to the reset state for the next file
      phase_q    <= PhRiff;
      bidx_q     <= '0;
      tag_q      <= '0;
      len_q      <= '0;
      fcnt_q     <= '0;
      riff_ok_q  <= 1'b0;
      fmt_q      <= '0;
      chans_q    <= '0;
      bits_q     <= '0;
      rate_q     <= '0;
      stg_q      <= '0;
      stg_bits_q <= '0;
      low_q      <= '0;
      seen_q     <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      bidx_q     <= bidx_d;
      tag_q      <= tag_d;
      len_q      <= len_d;
      fcnt_q     <= fcnt_d;
      riff_ok_q  <= riff_ok_d;
      fmt_q      <= fmt_d;
      chans_q    <= chans_d;
      bits_q     <= bits_d;
      rate_q     <= rate_d;
      stg_q      <= stg_d;
      stg_bits_q <= stg_bits_d;
      low_q      <= low_d;
      seen_q     <= seen_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue: up to two pushes, one pop per cycle
  // ---------------------------------------------------------------------
  result_t           q_mem [QDepth];
  logic [QPtrW-1:0]  wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0]  cnt_q, cnt_d;
  logic              pop;
  logic [1:0]        n_push;
  logic [QPtrW-1:0]  wr_nxt;

  assign pop        = out_valid_o && !out_stall_i;
  assign n_push     = {1'b0, emit_sample} + {1'b0, eof_acc};
  assign wr_nxt     = wr_q + QPtrW'(1);
  assign wr_d       = wr_q + QPtrW'(n_push);
  assign rd_d       = rd_q + QPtrW'(pop);
  assign cnt_d      = cnt_q + QCntW'(n_push) - QCntW'(pop);

  // room for two results is needed before a byte is taken
  assign in_stall_o = cnt_q > QCntW'(QDepth - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_sample) begin
      q_mem[wr_q] <= res_smp;
      if (eof_acc) begin
        q_mem[wr_nxt] <= res_st;
      end
    end else if (eof_acc) begin
      q_mem[wr_q] <= res_st;
    end
  end

  result_t head;
  assign head              = q_mem[rd_q];
  assign out_valid_o       = cnt_q != '0;
  assign out_kind_o        = head.kind;
  assign out_sample_o      = head.sample;
  assign out_status_o      = head.status;
  assign out_sample_rate_o = head.sample_rate;
  assign out_last_o        = head.last;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_q_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("result queue overflow");

  a_eof_rewind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_acc |=> (phase_q == PhRiff) && (fcnt_q == '0) && !seen_q)
    else $error("parser not rewound after end mark");

  a_walk_needs_riff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !riff_ok_q |-> (phase_q == PhRiff) || (phase_q == PhDone))
    else $error("chunk walk without valid RIFF/WAVE tags");

  a_fcnt_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= MinFileBytes)
    else $error("byte count past saturation");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_kind_o == out_last_o))
    else $error("status result and last flag disagree");

endmodule
